// ===== design/rzat_pkg.sv =====
`default_nettype none

package rzat_pkg;

    localparam int MAX_RAID_ZONES_DEF   = 1024;
    localparam int MAX_DEVICES_DEF      = 8;
    localparam int DEVICE_ZONE_BITS_DEF = 16;

    localparam int POS_W       = 48;
    localparam int DIV_W       = 29;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 33;
    localparam int CNT_W       = 5;

    localparam logic [1:0] CMD_MAP_WR  = 2'd0;
    localparam logic [1:0] CMD_MODE_WR = 2'd1;
    localparam logic [1:0] CMD_XLATE   = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_RAID0 = 2'd3;

    localparam logic [1:0] REG_DEVICE_COUNT   = 2'd0;
    localparam logic [1:0] REG_BLOCK_LOG2     = 2'd1;
    localparam logic [1:0] REG_DEV_ZONE_LOG2  = 2'd2;

    localparam logic [3:0] DEVICE_COUNT_RST   = 4'd1;
    localparam logic [4:0] BLOCK_LOG2_RST     = 5'd12;
    localparam logic [5:0] DEV_ZONE_LOG2_RST  = 6'd28;
    localparam logic [4:0] BLOCK_LOG2_MIN     = 5'd9;
    localparam logic [4:0] BLOCK_LOG2_MAX     = 5'd16;
    localparam logic [5:0] DEV_ZONE_LOG2_MIN  = 6'd16;
    localparam logic [5:0] DEV_ZONE_LOG2_MAX  = 6'd34;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  raid_zone;
        logic [2:0]  member_slot;
        logic [2:0]  device_in;
        logic [15:0] device_zone_in;
        logic [1:0]  mode_in;
        logic [47:0] logical_pos;
    } t_item;

    typedef struct packed {
        logic [2:0]  device_index;
        logic [47:0] device_pos;
        logic [1:0]  mode_out;
        logic        error;
    } t_result;

    // Reciprocal ceil(2^33 / n) for a divisor from 3 to 15 that is not a power of two, zero otherwise.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        unique case (n)
            5'd3:    m = 32'd2863311531;
            5'd5:    m = 32'd1717986919;
            5'd6:    m = 32'd1431655766;
            5'd7:    m = 32'd1227133514;
            5'd9:    m = 32'd954437177;
            5'd10:   m = 32'd858993460;
            5'd11:   m = 32'd780903145;
            5'd12:   m = 32'd715827883;
            5'd13:   m = 32'd660764200;
            5'd14:   m = 32'd613566757;
            5'd15:   m = 32'd572662307;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] shift_of(input logic [CNT_W-1:0] n);
        logic [2:0] s;
        unique case (n)
            5'd2:    s = 3'd1;
            5'd4:    s = 3'd2;
            5'd8:    s = 3'd3;
            5'd16:   s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/raid_zone_address_translator.sv =====
`default_nettype none

// Channel  | Signals                                   | Beat taken when
// command  | start, busy, i_item                       | start high and busy low
// result   | o_done, o_result                          | o_done high, one cycle
// config   | psel, penable, pwrite, paddr, pwdata,     | psel, penable, pwrite, pready high
//          | prdata, pready                            |
//
// One command enters per cycle while busy is low and flows through the control pipeline r_p.
// The pipeline holds two reciprocal multipliers by the device count and two table reads.
// After reset, busy stays high while the mode table is cleared.
// The receiver cannot stall; o_done marks each result for exactly one cycle.

module raid_zone_address_translator #(
    parameter int MAX_RAID_ZONES   = rzat_pkg::MAX_RAID_ZONES_DEF,
    parameter int MAX_DEVICES      = rzat_pkg::MAX_DEVICES_DEF,
    parameter int DEVICE_ZONE_BITS = rzat_pkg::DEVICE_ZONE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rzat_pkg::t_item   i_item,
    output logic                   o_done,
    output rzat_pkg::t_result      o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int RZW       = (MAX_RAID_ZONES > 1) ? $clog2(MAX_RAID_ZONES) : 1;
    localparam int SW        = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int MAP_DEPTH = MAX_RAID_ZONES * MAX_DEVICES;
    localparam int MW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int LIMW      = $clog2(MAP_DEPTH + 1);
    localparam int EW        = 3 + DEVICE_ZONE_BITS;
    localparam int DW        = rzat_pkg::DIV_W;
    localparam int PW        = rzat_pkg::POS_W;
    localparam int CW        = rzat_pkg::CNT_W;
    localparam int PROD_W    = rzat_pkg::DIV_W + rzat_pkg::RECIP_W;
    localparam int NSTAGE    = 9;
    localparam int PIPE_LAT  = 10;

    typedef struct packed {
        logic            vld;
        logic            err;
        logic [RZW-1:0]  zone;
        rzat_pkg::t_item item;
    } t_stage;

    logic [3:0] r_cfg_count;
    logic [4:0] r_cfg_blk;
    logic [5:0] r_cfg_dz;

    logic [CW-1:0] w_n;
    logic [4:0]    w_b;
    logic [5:0]    w_d;
    logic [5:0]    w_db;
    logic [rzat_pkg::RECIP_W-1:0] w_recip;
    logic [2:0]    w_nshift;
    logic          w_npow2;

    logic           r_clr_busy;
    logic [RZW-1:0] r_clr_addr;

    t_stage r_p [1:NSTAGE];
    t_stage n_p1;
    t_stage n_p2;
    t_stage n_p4;

    logic [31:0]       w_q_full;
    logic [LIMW-1:0]   w_zone_lim;
    logic [DW-1:0]     r_q2;
    logic [PROD_W-1:0] r_prod3;
    logic [DW-1:0]     r_q3;
    logic [DW-1:0]     w_rz;
    logic [DW-1:0]     r_q4;

    logic [1:0]     r_mode_mem [MAX_RAID_ZONES];
    logic [1:0]     r_mode_rd;
    logic [RZW-1:0] w_mode_addr;
    logic           w_mode_we;
    logic [1:0]     w_mode_wdata;
    logic [SW-1:0]  r_rem5;

    logic [1:0]     w_mode5;
    logic [DW-1:0]  w_blk5;
    logic [DW-1:0]  r_blk6;
    logic [1:0]     r_mode6;
    logic [SW-1:0]  r_rem6;

    logic [PROD_W-1:0] r_prod7;
    logic [DW-1:0]     r_blk7;
    logic [1:0]        r_mode7;
    logic [SW-1:0]     r_rem7;

    logic [DW-1:0]  w_row7;
    logic [DW-1:0]  r_row8;
    logic [DW-1:0]  r_blk8;
    logic [1:0]     r_mode8;
    logic [SW-1:0]  r_rem8;

    logic [SW-1:0]  w_s8;
    logic [PW-1:0]  w_inner8;
    logic           w_slot_err8;
    logic [MW-1:0]  w_map_addr;
    logic           w_map_we;
    logic [EW-1:0]  r_map_mem [MAP_DEPTH];
    logic [EW-1:0]  r_map_rd;
    logic [PW-1:0]  r_inner9;
    logic [1:0]     r_mode9;
    logic           r_slot_err9;

    logic [PW-1:0]           w_dpos9;
    rzat_pkg::t_result       n_res;
    rzat_pkg::t_result       r_res;
    logic                    r_done;

    // Configuration registers and their sanitized values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= rzat_pkg::DEVICE_COUNT_RST;
            r_cfg_blk   <= rzat_pkg::BLOCK_LOG2_RST;
            r_cfg_dz    <= rzat_pkg::DEV_ZONE_LOG2_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                rzat_pkg::REG_DEVICE_COUNT:  r_cfg_count <= pwdata[3:0];
                rzat_pkg::REG_BLOCK_LOG2:    r_cfg_blk   <= pwdata[4:0];
                rzat_pkg::REG_DEV_ZONE_LOG2: r_cfg_dz    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rzat_pkg::REG_DEVICE_COUNT:  prdata = 32'(r_cfg_count);
            rzat_pkg::REG_BLOCK_LOG2:    prdata = 32'(r_cfg_blk);
            rzat_pkg::REG_DEV_ZONE_LOG2: prdata = 32'(r_cfg_dz);
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_comb begin
        priority if (r_cfg_count == 4'd0) begin
            w_n = CW'(1);
        end else if (CW'(r_cfg_count) > CW'(MAX_DEVICES)) begin
            w_n = CW'(MAX_DEVICES);
        end else begin
            w_n = CW'(r_cfg_count);
        end
        priority if (r_cfg_blk < rzat_pkg::BLOCK_LOG2_MIN) begin
            w_b = rzat_pkg::BLOCK_LOG2_MIN;
        end else if (r_cfg_blk > rzat_pkg::BLOCK_LOG2_MAX) begin
            w_b = rzat_pkg::BLOCK_LOG2_MAX;
        end else begin
            w_b = r_cfg_blk;
        end
        priority if (r_cfg_dz < rzat_pkg::DEV_ZONE_LOG2_MIN) begin
            w_d = rzat_pkg::DEV_ZONE_LOG2_MIN;
        end else if (r_cfg_dz > rzat_pkg::DEV_ZONE_LOG2_MAX) begin
            w_d = rzat_pkg::DEV_ZONE_LOG2_MAX;
        end else begin
            w_d = r_cfg_dz;
        end
    end

    assign w_db     = w_d - 6'(w_b);
    assign w_recip  = rzat_pkg::recip_of(w_n);
    assign w_nshift = rzat_pkg::shift_of(w_n);
    assign w_npow2  = (w_recip == '0);

    // Mode table clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + RZW'(1);
            if (r_clr_addr == RZW'(MAX_RAID_ZONES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign busy = r_clr_busy;

    // Control pipeline.
    always_comb begin
        n_p1      = r_p[1];
        n_p1.vld  = start && !r_clr_busy;
        n_p1.err  = 1'b0;
        n_p1.zone = '0;
        n_p1.item = i_item;
    end

    assign w_q_full   = 32'(r_p[1].item.logical_pos >> w_d);
    assign w_zone_lim = LIMW'(w_n) * LIMW'(MAX_RAID_ZONES);

    always_comb begin
        n_p2      = r_p[1];
        n_p2.zone = RZW'(r_p[1].item.raid_zone);
        unique case (r_p[1].item.cmd)
            rzat_pkg::CMD_XLATE:   n_p2.err = (w_q_full >= 32'(w_zone_lim));
            rzat_pkg::CMD_MAP_WR,
            rzat_pkg::CMD_MODE_WR: n_p2.err =
                (32'(r_p[1].item.raid_zone) >= 32'(MAX_RAID_ZONES));
            default:               n_p2.err = 1'b1;
        endcase
    end

    assign w_rz = w_npow2 ? (r_q3 >> w_nshift) : DW'(r_prod3 >> rzat_pkg::RECIP_SHIFT);

    always_comb begin
        n_p4 = r_p[3];
        if (r_p[3].item.cmd == rzat_pkg::CMD_XLATE) begin
            n_p4.zone = RZW'(w_rz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NSTAGE; k++) begin
                r_p[k].vld <= 1'b0;
            end
        end else begin
            r_p[1] <= n_p1;
            r_p[2] <= n_p2;
            r_p[3] <= r_p[2];
            r_p[4] <= n_p4;
            for (int k = 5; k <= NSTAGE; k++) begin
                r_p[k] <= r_p[k-1];
            end
        end
    end

    // Zone division by the device count.
    always_ff @(posedge i_clk) begin
        r_q2    <= DW'(w_q_full);
        r_prod3 <= PROD_W'(r_q2) * PROD_W'(w_recip);
        r_q3    <= r_q2;
        r_q4    <= r_q3;
    end

    // Mode table: read and written at the same stage, so program order holds.
    assign w_mode_addr  = r_clr_busy ? r_clr_addr : r_p[4].zone;
    assign w_mode_we    = r_clr_busy || (r_p[4].vld && !r_p[4].err
                          && r_p[4].item.cmd == rzat_pkg::CMD_MODE_WR);
    assign w_mode_wdata = r_clr_busy ? rzat_pkg::MODE_NONE : r_p[4].item.mode_in;

    always_ff @(posedge i_clk) begin
        if (w_mode_we) begin
            r_mode_mem[w_mode_addr] <= w_mode_wdata;
        end
        r_mode_rd <= r_mode_mem[w_mode_addr];
        r_rem5    <= SW'(r_q4 - DW'(r_p[4].zone) * DW'(w_n));
    end

    // Block index within the raid zone.
    assign w_mode5 = (r_p[5].item.cmd == rzat_pkg::CMD_MODE_WR) ?
                     r_p[5].item.mode_in : r_mode_rd;
    assign w_blk5  = (DW'(r_rem5) << w_db)
                   | DW'((r_p[5].item.logical_pos >> w_b) & ((48'd1 << w_db) - 48'd1));

    assign w_row7 = w_npow2 ? (r_blk7 >> w_nshift) : DW'(r_prod7 >> rzat_pkg::RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        r_blk6  <= w_blk5;
        r_mode6 <= w_mode5;
        r_rem6  <= r_rem5;
        r_prod7 <= PROD_W'(r_blk6) * PROD_W'(w_recip);
        r_blk7  <= r_blk6;
        r_mode7 <= r_mode6;
        r_rem7  <= r_rem6;
        r_row8  <= w_row7;
        r_blk8  <= r_blk7;
        r_mode8 <= r_mode7;
        r_rem8  <= r_rem7;
    end

    // Slot selection and slot map access.
    always_comb begin
        if (r_mode8 == rzat_pkg::MODE_RAID0) begin
            w_s8     = SW'(r_blk8 - DW'(r_row8) * DW'(w_n));
            w_inner8 = (PW'(r_row8) << w_b)
                     + (r_p[8].item.logical_pos & ((48'd1 << w_b) - 48'd1));
        end else begin
            w_s8     = r_rem8;
            w_inner8 = r_p[8].item.logical_pos & ((48'd1 << w_d) - 48'd1);
        end
    end

    assign w_slot_err8 = (CW'(r_p[8].item.member_slot) >= w_n);
    assign w_map_addr  = MW'(r_p[8].zone) * MW'(MAX_DEVICES)
                       + MW'((r_p[8].item.cmd == rzat_pkg::CMD_MAP_WR) ?
                             SW'(r_p[8].item.member_slot) : w_s8);
    assign w_map_we    = r_p[8].vld && !r_p[8].err && !w_slot_err8
                       && r_p[8].item.cmd == rzat_pkg::CMD_MAP_WR;

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_map_mem[w_map_addr] <= {r_p[8].item.device_in,
                                      DEVICE_ZONE_BITS'(r_p[8].item.device_zone_in)};
        end
        r_map_rd    <= r_map_mem[w_map_addr];
        r_inner9    <= w_inner8;
        r_mode9     <= r_mode8;
        r_slot_err9 <= w_slot_err8;
    end

    // Result assembly.
    assign w_dpos9 = (PW'(r_map_rd[DEVICE_ZONE_BITS-1:0]) << w_d) + r_inner9;

    always_comb begin
        n_res = '0;
        if (r_p[9].err) begin
            n_res.error = 1'b1;
        end else begin
            unique case (r_p[9].item.cmd)
                rzat_pkg::CMD_XLATE: begin
                    n_res.device_index = r_map_rd[EW-1 -: 3];
                    n_res.device_pos   = w_dpos9;
                    n_res.mode_out     = r_mode9;
                end
                rzat_pkg::CMD_MAP_WR: begin
                    n_res.mode_out = r_mode9;
                    n_res.error    = r_slot_err9;
                end
                rzat_pkg::CMD_MODE_WR: begin
                    n_res.mode_out = r_mode9;
                end
                default: begin
                    n_res.error = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_p[9].vld;
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_done)
        else $error("accepted command produced no result at the expected cycle");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result delivered during the clearing pass");

    a_clear_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_p[4].vld)
        else $error("mode table access collides with the clearing pass");

    a_error_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.error) |-> (o_result.device_pos == '0
                                        && o_result.device_index == '0))
        else $error("error result carries a device position");
`endif

endmodule

`default_nettype wire
